### rtl/swpt_pkg.sv
// ----------------------------------------------------------------------------
// swpt_pkg - switch press duration timer package
// Shared payload types, register indexes, reset values and the command
// group that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package swpt_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SW_IDX_W   = 3;
  localparam int unsigned EN_W       = 8;
  localparam int unsigned MIN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Request codes
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_POLL   = 1'b1;

  // Switch levels (active low)
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_US = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS_US  = 2'd2;

  // Register reset values
  localparam logic [EN_W-1:0]   RST_SWITCH_ENABLE = 8'd0;
  localparam logic [TIME_W-1:0] RST_LONG_PRESS_US = 32'd2000000;
  localparam logic [MIN_W-1:0]  RST_MIN_PRESS_US  = 16'd1000;

  typedef struct packed {
    logic                req_type;
    logic [SW_IDX_W-1:0] switch_index;
    logic                level;
    logic [TIME_W-1:0]   now_us;
  } in_item_t;

  typedef struct packed {
    logic              has_duration;
    logic [TIME_W-1:0] duration_us;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;  // capture the input transfer
    logic exec_item;  // run the item and load the result register
  } dp_cmd_t;

endpackage

### rtl/switch_press_duration_timer_top.sv
// ----------------------------------------------------------------------------
// switch_press_duration_timer_top - switch press duration timer
// Sequence: the execute step after the input transfer loads the result
//   register and waits while an earlier result is stalled. One item at a
//   time: an item's single read-modify-write ends before the next is taken.
// Reset: synchronous, active low; registers to their defaults, all switches
//   released and disarmed, no stored durations.
// ----------------------------------------------------------------------------
module switch_press_duration_timer_top #(
  parameter int unsigned NUM_SWITCHES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swpt_pkg::in_item_t              in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output swpt_pkg::out_item_t             out_data,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [swpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import swpt_pkg::*;

  // Commands from the controller: capture on input transfer, then one
  // execute cycle that updates the switch state and loads the result
  // register. The execute cycle waits while an earlier result is stalled.
  dp_cmd_t cmd;

  swpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: registers, per-switch level/armed/start/held state, one
  // wrapping subtract and compares against the thresholds.
  swpt_dp #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

### rtl/swpt_ctrl.sv
// ----------------------------------------------------------------------------
// swpt_ctrl - switch press duration timer controller
// Sequences one item at a time and owns both handshakes.
// ----------------------------------------------------------------------------
module swpt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output swpt_pkg::dp_cmd_t cmd
);
  import swpt_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   exec_go;

  assign in_ready = (state_r == ST_IDLE);
  // result register free, or emptied by this cycle's transfer
  assign exec_go  = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign cmd.load_item = in_valid && in_ready;
  assign cmd.exec_item = exec_go;
  assign out_valid     = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/swpt_dp.sv
// ----------------------------------------------------------------------------
// swpt_dp - switch press duration timer datapath
// Configuration registers, per-switch timing state and the result register.
// ----------------------------------------------------------------------------
module swpt_dp #(
  parameter int unsigned NUM_SWITCHES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swpt_pkg::dp_cmd_t                   cmd,
  input  swpt_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [swpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swpt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output swpt_pkg::out_item_t                 out_data
);
  import swpt_pkg::*;

  localparam int unsigned IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
  localparam int unsigned WIDE_W = 8;

  // configuration
  logic [EN_W-1:0]   switch_enable_r;
  logic [TIME_W-1:0] long_press_us_r;
  logic [MIN_W-1:0]  min_press_us_r;

  // per-switch state
  logic [NUM_SWITCHES-1:0] level_r, level_nxt;
  logic [NUM_SWITCHES-1:0] armed_r, armed_nxt;
  logic [TIME_W-1:0]       start_r [NUM_SWITCHES];
  logic [TIME_W-1:0]       start_nxt [NUM_SWITCHES];
  logic [TIME_W-1:0]       held_r  [NUM_SWITCHES];
  logic [TIME_W-1:0]       held_nxt  [NUM_SWITCHES];

  in_item_t  item_r;
  out_item_t result_r, result_nxt;

  logic [WIDE_W-1:0] idx_wide;
  logic [IDX_W-1:0]  sel;
  logic              in_range;
  logic              sw_en;
  logic [TIME_W-1:0] run_time;
  logic [TIME_W-1:0] stored;
  logic [TIME_W-1:0] dur;

  assign idx_wide = {{(WIDE_W - SW_IDX_W){1'b0}}, item_r.switch_index};
  assign sel      = idx_wide[IDX_W-1:0];
  assign in_range = (idx_wide < WIDE_W'(NUM_SWITCHES));
  assign sw_en    = switch_enable_r[item_r.switch_index];
  assign run_time = item_r.now_us - start_r[sel];
  assign stored   = held_r[sel];

  always_comb begin
    level_nxt = level_r;
    armed_nxt = armed_r;
    start_nxt = start_r;
    held_nxt  = held_r;
    dur       = '0;
    if (in_range) begin
      if (item_r.req_type == REQ_UPDATE) begin
        if (sw_en && (level_r[sel] != item_r.level)) begin
          level_nxt[sel] = item_r.level;
          if (item_r.level == LVL_RELEASED) begin
            if (armed_r[sel]) begin
              armed_nxt[sel] = 1'b0;
              if (run_time >= {{(TIME_W - MIN_W){1'b0}}, min_press_us_r}) begin
                held_nxt[sel] = run_time;
              end
            end
          end else begin
            start_nxt[sel] = item_r.now_us;
            armed_nxt[sel] = 1'b1;
          end
        end
      end else begin
        if (stored != '0) begin
          held_nxt[sel] = '0;
          dur           = stored;
        end else if (armed_r[sel] && (run_time > long_press_us_r)) begin
          armed_nxt[sel] = 1'b0;
          dur            = run_time;
        end
      end
    end
    result_nxt.has_duration = (dur != '0);
    result_nxt.duration_us  = dur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_enable_r <= RST_SWITCH_ENABLE;
      long_press_us_r <= RST_LONG_PRESS_US;
      min_press_us_r  <= RST_MIN_PRESS_US;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWITCH_ENABLE: switch_enable_r <= cfg_wdata[EN_W-1:0];
        CFG_LONG_PRESS_US: long_press_us_r <= cfg_wdata[TIME_W-1:0];
        CFG_MIN_PRESS_US:  min_press_us_r  <= cfg_wdata[MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // press start needs no reset: it is only read while the switch is armed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '1;
      armed_r <= '0;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        held_r[i] <= '0;
      end
    end else if (cmd.exec_item) begin
      level_r <= level_nxt;
      armed_r <= armed_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_item) begin
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.exec_item) begin
      result_r <= result_nxt;
    end
  end

  assign out_data = result_r;

endmodule
